// ===== rtl/rts_ratio_send_rate_controller_assert.svh =====
// Assertion helpers for the controller FSM.
`ifndef RTS_RATIO_SEND_RATE_CONTROLLER_ASSERT_SVH
`define RTS_RATIO_SEND_RATE_CONTROLLER_ASSERT_SVH
// Check that a condition implies a consequence in the same cycle.
`define RTS_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("%m: lbl failed");
// Check that a condition implies a consequence in the next cycle.
`define RTS_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("%m: lbl failed");
`endif

// ===== rtl/rts_pkg.sv =====
package rts_pkg;
  localparam logic [1:0] MODE_UNPACED = 2'd0;
  localparam logic [1:0] MODE_SLOW    = 2'd1;
  localparam logic [1:0] MODE_SEARCH  = 2'd2;
  localparam logic [1:0] MODE_STABLE  = 2'd3;
  localparam logic [1:0] CLS_BELOW    = 2'd0;
  localparam logic [1:0] CLS_INSIDE   = 2'd1;
  localparam logic [1:0] CLS_ABOVE    = 2'd2;
  localparam logic [1:0] TMR_NONE     = 2'd0;
  localparam logic [1:0] TMR_RESTART  = 2'd1;
  localparam logic [1:0] TMR_CANCEL   = 2'd2;
  localparam logic [2:0] REG_LOW_TH   = 3'd0;
  localparam logic [2:0] REG_HIGH_TH  = 3'd1;
  localparam logic [2:0] REG_SETTLE   = 3'd2;
  localparam logic [2:0] REG_BLOCKED  = 3'd3;
  localparam logic [2:0] REG_TOL      = 3'd4;
  localparam logic [31:0] PEAK_NUM    = 32'd4096000000;
  localparam int DIV_STEPS = 32;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EVAL, ST_DIV, ST_DONE, ST_OUT
  } state_t;

  typedef struct packed {
    logic eval;      // run one sample or timer update
    logic div_start; // load the divider
    logic div_step;  // one restoring step
    logic div_done;  // commit slow start entry
    logic out_load;  // capture the result item
  } cmd_t;

  typedef struct packed {
    logic need_div;  // item enters slow start
    logic div_last;  // divider on its final step
  } stat_t;
endpackage

// ===== rtl/rts_datapath.sv =====
module rts_datapath #(
  parameter int SAMPLE_WINDOW = 10,
  parameter int STATUS_WINDOW = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rts_pkg::cmd_t      cmd,
  output rts_pkg::stat_t     stat,
  input  logic               it_action,
  input  logic [15:0]        it_ratio,
  input  logic [23:0]        it_tus,
  input  logic               it_cong,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [31:0]        cfg_wdata,
  output logic [31:0]        cfg_rdata,
  output logic [1:0]         o_mode,
  output logic [31:0]        o_rate,
  output logic               o_mrc,
  output logic               o_send,
  output logic [1:0]         o_tmr
);
  import rts_pkg::*;
  localparam int SW = $clog2(SAMPLE_WINDOW + 1);
  localparam int CW = $clog2(STATUS_WINDOW + 1);
  localparam int DCW = $clog2(DIV_STEPS);

  logic [15:0] low_init_r, high_init_r, low_th_r, high_th_r;
  logic [4:0]  settle_r;
  logic [5:0]  blocked_r;
  logic [19:0] tol_r;
  logic [1:0]  mode_r;
  logic [31:0] cur_r, top_r, bot_r, peak_r;
  logic [1:0]  cring_r [SAMPLE_WINDOW];
  logic [SW-1:0] cfill_r, below_r, inside_r, above_r;
  logic        gring_r [STATUS_WINDOW];
  logic [CW-1:0] gfill_r, gtot_r;
  logic        sat_r;
  logic        send_r;
  logic [1:0]  tmr_r;
  // divider
  logic [31:0] q_r, rem_r;
  logic [23:0] dvs_r;
  logic [DCW-1:0] dcnt_r;
  logic [15:0] lthr_nxt_r;

  // sample and status window update values
  logic [1:0]  cls;
  logic [SW-1:0] b_n, i_n, a_n;
  logic [CW-1:0] g_n;
  always_comb begin
    if (it_ratio < low_th_r) cls = CLS_BELOW;
    else if (it_ratio < high_th_r) cls = CLS_INSIDE;
    else cls = CLS_ABOVE;
    b_n = below_r; i_n = inside_r; a_n = above_r;
    if (cfill_r >= SW'(SAMPLE_WINDOW)) begin
      case (cring_r[SAMPLE_WINDOW-1])
        CLS_BELOW:  if (b_n != '0) b_n = b_n - 1'b1;
        CLS_INSIDE: if (i_n != '0) i_n = i_n - 1'b1;
        default:    if (a_n != '0) a_n = a_n - 1'b1;
      endcase
    end
    case (cls)
      CLS_BELOW:  b_n = b_n + 1'b1;
      CLS_INSIDE: i_n = i_n + 1'b1;
      default:    a_n = a_n + 1'b1;
    endcase
    g_n = gtot_r;
    if (gfill_r >= CW'(STATUS_WINDOW) && gring_r[STATUS_WINDOW-1] && g_n != '0)
      g_n = g_n - 1'b1;
    if (it_cong) g_n = g_n + 1'b1;
  end

  function automatic logic [31:0] rate_gap(logic [31:0] a, logic [31:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Sample that drops the controller back to unpaced.
  logic fall_back;
  always_comb begin
    fall_back = 1'b0;
    if (!(sat_r && mode_r != MODE_UNPACED)) begin
      if (mode_r == MODE_SEARCH && !(32'(i_n) > 32'(settle_r))) begin
        if (it_ratio < low_th_r) fall_back = rate_gap(cur_r, top_r) < 32'(tol_r);
        else if (it_ratio > high_th_r) fall_back = rate_gap(cur_r, bot_r) < 32'(tol_r);
      end else if (mode_r == MODE_STABLE) begin
        fall_back = 32'(b_n) > 32'(settle_r);
      end
    end
  end

  logic [32:0] sum_top, sum_bot, dbl;
  logic [32:0] rem_sh;
  logic [17:0] l3;
  logic [35:0] l3_prod;
  assign sum_top = {1'b0, cur_r} + {1'b0, top_r};
  assign sum_bot = {1'b0, cur_r} + {1'b0, bot_r};
  assign dbl     = {cur_r, 1'b0};
  assign rem_sh  = {rem_r, q_r[31]};
  assign l3      = 18'(3 * it_ratio) + 18'd1792;
  // divide by 10 through the reciprocal ceil(2^21 / 10); exact for this range
  assign l3_prod = 36'(l3) * 36'd209716;

  assign stat.need_div = !it_action && (mode_r == MODE_UNPACED);
  assign stat.div_last = (dcnt_r == DCW'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_init_r <= '0; high_init_r <= '0; low_th_r <= '0; high_th_r <= '0;
      settle_r <= 5'd7; blocked_r <= 6'd10; tol_r <= 20'd1000;
      mode_r <= MODE_UNPACED; cur_r <= '0; top_r <= '0; bot_r <= '0; peak_r <= '0;
      cfill_r <= '0; below_r <= '0; inside_r <= '0; above_r <= '0;
      gfill_r <= '0; gtot_r <= '0; sat_r <= 1'b0;
      send_r <= 1'b0; tmr_r <= TMR_NONE; dcnt_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_LOW_TH:  begin low_init_r <= cfg_wdata[15:0]; low_th_r <= cfg_wdata[15:0]; end
          REG_HIGH_TH: begin high_init_r <= cfg_wdata[15:0]; high_th_r <= cfg_wdata[15:0]; end
          REG_SETTLE:  settle_r <= cfg_wdata[4:0];
          REG_BLOCKED: blocked_r <= cfg_wdata[5:0];
          REG_TOL:     tol_r <= cfg_wdata[19:0];
          default: ;
        endcase
      end
      if (cmd.eval) begin
        if (it_action) begin
          gfill_r <= (gfill_r >= CW'(STATUS_WINDOW)) ? CW'(STATUS_WINDOW) : gfill_r + 1'b1;
          gtot_r <= g_n;
          sat_r <= 32'(g_n) > 32'(blocked_r);
          send_r <= !it_cong;
          tmr_r <= (mode_r != MODE_UNPACED) ? TMR_RESTART : TMR_NONE;
        end else begin
          send_r <= fall_back;
          tmr_r <= fall_back ? TMR_CANCEL : TMR_NONE;
          cfill_r <= (cfill_r >= SW'(SAMPLE_WINDOW)) ? SW'(SAMPLE_WINDOW) : cfill_r + 1'b1;
          below_r <= b_n; inside_r <= i_n; above_r <= a_n;
          if (sat_r && mode_r != MODE_UNPACED) begin
            mode_r <= MODE_SEARCH; top_r <= cur_r; bot_r <= '0; cur_r <= cur_r >> 1;
          end else if (mode_r == MODE_SLOW) begin
            if (32'(i_n) > 32'(settle_r)) mode_r <= MODE_STABLE;
            else if (it_ratio < low_th_r)
              cur_r <= (dbl > {1'b0, peak_r}) ? peak_r : dbl[31:0];
            else if (it_ratio > high_th_r) begin
              mode_r <= MODE_SEARCH; top_r <= cur_r; bot_r <= '0; cur_r <= cur_r >> 1;
            end
          end else if (mode_r == MODE_SEARCH) begin
            if (32'(i_n) > 32'(settle_r)) mode_r <= MODE_STABLE;
            else if (it_ratio < low_th_r) begin
              if (rate_gap(cur_r, top_r) < 32'(tol_r)) begin
                mode_r <= MODE_UNPACED;
              end else begin
                bot_r <= cur_r;
                cur_r <= (sum_top[32:1] > peak_r) ? peak_r : sum_top[32:1];
              end
            end else if (it_ratio > high_th_r) begin
              if (rate_gap(cur_r, bot_r) < 32'(tol_r)) begin
                mode_r <= MODE_UNPACED;
              end else begin
                top_r <= (cur_r > peak_r) ? peak_r : cur_r;
                cur_r <= sum_bot[32:1];
              end
            end
          end else if (mode_r == MODE_STABLE) begin
            if (32'(b_n) > 32'(settle_r)) begin
              mode_r <= MODE_UNPACED;
            end else if (32'(a_n) > 32'(settle_r)) begin
              mode_r <= MODE_SEARCH; top_r <= cur_r; bot_r <= '0; cur_r <= cur_r >> 1;
            end
          end
        end
      end
      if (cmd.div_start) begin
        dcnt_r <= '0;
        high_th_r <= 16'd128 + {1'b0, it_ratio[15:1]};
        lthr_nxt_r <= {1'b0, l3_prod[35:21]};
      end
      if (cmd.div_step) dcnt_r <= dcnt_r + 1'b1;
      if (cmd.div_done) begin
        mode_r <= MODE_SLOW;
        peak_r <= (dvs_r == '0) ? 32'hFFFF_FFFF : q_r;
        cur_r  <= (dvs_r == '0) ? 32'h7FFF_FFFF : {1'b0, q_r[31:1]};
        low_th_r <= lthr_nxt_r;
        cfill_r <= '0; below_r <= '0; inside_r <= '0; above_r <= '0;
        send_r <= 1'b0; tmr_r <= TMR_RESTART;
      end
    end
  end

  // restoring divider, one quotient bit a cycle; q_r shifts dividend out
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      q_r <= PEAK_NUM; rem_r <= '0; dvs_r <= it_tus;
    end else if (cmd.div_step) begin
      if (rem_sh >= {9'd0, dvs_r}) begin
        rem_r <= 32'(rem_sh - {9'd0, dvs_r});
        q_r <= {q_r[30:0], 1'b1};
      end else begin
        rem_r <= rem_sh[31:0];
        q_r <= {q_r[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && !it_action) begin
      for (int k = SAMPLE_WINDOW-1; k > 0; k--) cring_r[k] <= cring_r[k-1];
      cring_r[0] <= cls;
    end
    if (cmd.eval && it_action) begin
      for (int k = STATUS_WINDOW-1; k > 0; k--) gring_r[k] <= gring_r[k-1];
      gring_r[0] <= it_cong;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_mode <= mode_r; o_rate <= cur_r; o_mrc <= (mode_r != MODE_UNPACED);
      o_send <= send_r; o_tmr <= tmr_r;
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_LOW_TH:  cfg_rdata = {16'd0, low_init_r};
      REG_HIGH_TH: cfg_rdata = {16'd0, high_init_r};
      REG_SETTLE:  cfg_rdata = {27'd0, settle_r};
      REG_BLOCKED: cfg_rdata = {26'd0, blocked_r};
      REG_TOL:     cfg_rdata = {12'd0, tol_r};
      default:     cfg_rdata = '0;
    endcase
  end
endmodule

// ===== rtl/rts_ctrl.sv =====
`include "rts_ratio_send_rate_controller_assert.svh"
module rts_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  rts_pkg::stat_t  stat,
  output rts_pkg::cmd_t   cmd
);
  import rts_pkg::*;
  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ov_r <= ov_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    ov_nxt = ov_r && !out_ready;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (stat.need_div) begin
          cmd.div_start = 1'b1; state_nxt = ST_DIV;
        end else begin
          cmd.eval = 1'b1; state_nxt = ST_OUT;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        cmd.div_done = 1'b1; state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_r || out_ready) begin
          cmd.out_load = 1'b1; ov_nxt = 1'b1; state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
  assign out_valid = ov_r;

  `RTS_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, state_r == ST_IDLE)
  `RTS_ASSERT_NXT(a_load_valid, clk, rst_n, cmd.out_load, out_valid)
  `RTS_ASSERT_NXT(a_div_steps, clk, rst_n, cmd.div_start, state_r == ST_DIV)
endmodule

// ===== rtl/rts_ratio_send_rate_controller.sv =====
// Flow: an accepted item is evaluated, then its result is loaded to the outputs;
// a slow start entry first runs a 32-step restoring divider for the peak rate.
// A new item is taken only after the last result is loaded to the outputs; a result
// still waiting for out_ready stalls the next item for as long as it waits.
// Reset: synchronous active-low rst_n; mode unpaced, rates zero, windows empty.
module rts_ratio_send_rate_controller #(
  parameter int SAMPLE_WINDOW = 10,
  parameter int STATUS_WINDOW = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [15:0] in_ratio_sample,
  input  logic [23:0] in_min_send_time_us,
  input  logic        in_mac_congested,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_mode,
  output logic [31:0] out_send_rate,
  output logic        out_mac_rate_control,
  output logic        out_send_now,
  output logic [1:0]  out_timer_command,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rts_pkg::*;
  cmd_t  cmd;
  stat_t stat;
  // Capture the item at accept so the input side may move on.
  logic        act_r, cong_r;
  logic [15:0] ratio_r;
  logic [23:0] tus_r;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act_r <= in_action; ratio_r <= in_ratio_sample;
      tus_r <= in_min_send_time_us; cong_r <= in_mac_congested;
    end
  end

  assign pready = 1'b1;

  rts_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .stat, .cmd
  );

  // Writes land at the access phase; user keeps the block idle then; no hardware check.
  rts_datapath #(.SAMPLE_WINDOW(SAMPLE_WINDOW), .STATUS_WINDOW(STATUS_WINDOW)) u_dp (
    .clk, .rst_n, .cmd, .stat,
    .it_action(act_r), .it_ratio(ratio_r), .it_tus(tus_r), .it_cong(cong_r),
    .cfg_we(psel && penable && pwrite && pready),
    .cfg_idx(paddr[4:2]), .cfg_wdata(pwdata), .cfg_rdata(prdata),
    .o_mode(out_mode), .o_rate(out_send_rate), .o_mrc(out_mac_rate_control),
    .o_send(out_send_now), .o_tmr(out_timer_command)
  );
endmodule

// ===== test/tb_rts_ratio_send_rate_controller.sv =====
module tb_rts_ratio_send_rate_controller;
  import rts_pkg::*;

  typedef struct {
    logic        action;
    logic [15:0] ratio;
    logic [23:0] send_us;
    logic        congested;
  } rate_item_t;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] rate;
    logic        mac_rc;
    logic        send_now;
    logic [1:0]  tmr;
  } rate_update_t;

  localparam int STALL_LIMIT = 4000;
  localparam int ITEM_SLOTS  = 2048;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_action;
  logic [15:0] in_ratio_sample;
  logic [23:0] in_min_send_time_us;
  logic        in_mac_congested;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_mode;
  logic [31:0] out_send_rate;
  logic        out_mac_rate_control;
  logic        out_send_now;
  logic [1:0]  out_timer_command;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rts_ratio_send_rate_controller uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_ratio_sample(in_ratio_sample), .in_min_send_time_us(in_min_send_time_us),
    .in_mac_congested(in_mac_congested),
    .out_valid(out_valid), .out_ready(out_ready), .out_mode(out_mode),
    .out_send_rate(out_send_rate), .out_mac_rate_control(out_mac_rate_control),
    .out_send_now(out_send_now), .out_timer_command(out_timer_command),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Free-running clock, period 10.
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Items waiting for the driver, and updates waiting for the monitor.
  rate_item_t   pend_mem[ITEM_SLOTS];
  int           pend_head, pend_tail;
  rate_update_t exp_mem[ITEM_SLOTS];
  int           exp_head, exp_tail;
  int           mismatch_count;
  int           idle_cycles;
  bit           quiet_phase;  // no gaps or stalls while set

  // Shadow copy of the controller's registers.
  logic [15:0] sh_lo_init, sh_hi_init;
  logic [4:0]  sh_settle;
  logic [5:0]  sh_blocked;
  logic [19:0] sh_tol;

  // Shadow copy of the controller state.
  logic [1:0]  sh_mode;
  logic [31:0] rate_now, rate_top, rate_floor, rate_peak;
  logic [15:0] th_lo, th_hi;
  logic [1:0]  cls_win[10];
  int          cls_cnt, n_below, n_inside, n_above;
  logic        cg_win[20];
  int          cg_cnt, cg_total;
  bit          sat_flag;

  function automatic void bump_class(logic [1:0] c, bit up);
    if (c == CLS_BELOW) begin
      if (up) n_below++; else if (n_below > 0) n_below--;
    end else if (c == CLS_INSIDE) begin
      if (up) n_inside++; else if (n_inside > 0) n_inside--;
    end else begin
      if (up) n_above++; else if (n_above > 0) n_above--;
    end
  endfunction

  function automatic void enter_search();
    sh_mode    = MODE_SEARCH;
    rate_top   = rate_now;
    rate_floor = 32'd0;
    rate_now   = rate_now >> 1;
  endfunction

  // Advance the shadow state by one item and return the update it causes.
  function automatic rate_update_t next_rate_update(rate_item_t it);
    rate_update_t u;
    logic [1:0]   c;
    logic [32:0]  wide;
    logic [31:0]  rate_gap;
    logic [63:0]  q;
    bit           fall_back;
    fall_back  = 0;
    u.send_now = 1'b0;
    u.tmr      = TMR_NONE;
    if (it.action) begin
      // Record congestion in the status window.
      if (cg_cnt >= 20) begin
        if (cg_win[19] && cg_total > 0) cg_total--;
      end else begin
        cg_cnt++;
      end
      for (int i = 19; i > 0; i--) cg_win[i] = cg_win[i-1];
      cg_win[0] = it.congested;
      if (it.congested) cg_total++;
      sat_flag = cg_total > sh_blocked;
      if (!it.congested) u.send_now = 1'b1;
      if (sh_mode != MODE_UNPACED) u.tmr = TMR_RESTART;
    end else begin
      // Classify against the thresholds in force before this sample.
      if (it.ratio < th_lo) c = CLS_BELOW;
      else if (it.ratio < th_hi) c = CLS_INSIDE;
      else c = CLS_ABOVE;
      if (cls_cnt >= 10) bump_class(cls_win[9], 0);
      else cls_cnt++;
      for (int i = 9; i > 0; i--) cls_win[i] = cls_win[i-1];
      cls_win[0] = c;
      bump_class(c, 1);
      if (sat_flag && sh_mode != MODE_UNPACED) begin
        enter_search();
      end else if (sh_mode == MODE_UNPACED) begin
        sh_mode = MODE_SLOW;
        if (it.send_us == 0) begin
          rate_peak = 32'hFFFF_FFFF;
        end else begin
          q = 64'd4096000000 / it.send_us;
          rate_peak = q[31:0];
        end
        rate_now = rate_peak >> 1;
        th_hi = 16'd128 + (it.ratio >> 1);
        q = (64'd3 * it.ratio + 64'd1792) / 64'd10;
        th_lo = q[15:0];
        cls_cnt = 0; n_below = 0; n_inside = 0; n_above = 0;
        for (int i = 0; i < 10; i++) cls_win[i] = CLS_BELOW;
        u.tmr = TMR_RESTART;
      end else if (sh_mode == MODE_SLOW) begin
        if (n_inside > sh_settle) begin
          sh_mode = MODE_STABLE;
        end else if (it.ratio < th_lo) begin
          // Double, clamped to the peak.
          wide = {rate_now, 1'b0};
          rate_now = (wide > {1'b0, rate_peak}) ? rate_peak : wide[31:0];
        end else if (it.ratio > th_hi) begin
          enter_search();
        end
      end else if (sh_mode == MODE_SEARCH) begin
        if (n_inside > sh_settle) begin
          sh_mode = MODE_STABLE;
        end else if (it.ratio < th_lo) begin
          rate_gap = (rate_now > rate_top) ? rate_now - rate_top : rate_top - rate_now;
          if (rate_gap < sh_tol) begin
            fall_back = 1;
          end else begin
            wide = ({1'b0, rate_now} + {1'b0, rate_top}) >> 1;
            rate_floor = rate_now;
            rate_now = (wide > {1'b0, rate_peak}) ? rate_peak : wide[31:0];
          end
        end else if (it.ratio > th_hi) begin
          rate_gap = (rate_now > rate_floor) ? rate_now - rate_floor : rate_floor - rate_now;
          if (rate_gap < sh_tol) begin
            fall_back = 1;
          end else begin
            rate_top = (rate_now > rate_peak) ? rate_peak : rate_now;
            wide = ({1'b0, rate_now} + {1'b0, rate_floor}) >> 1;
            rate_now = wide[31:0];
          end
        end
      end else begin
        if (n_below > sh_settle) fall_back = 1;
        else if (n_above > sh_settle) enter_search();
      end
      if (fall_back) begin
        sh_mode    = MODE_UNPACED;
        u.send_now = 1'b1;
        u.tmr      = TMR_CANCEL;
      end
    end
    u.mode   = sh_mode;
    u.rate   = rate_now;
    u.mac_rc = (sh_mode != MODE_UNPACED);
    return u;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  function automatic int draw_gap();
    return quiet_phase ? 0 : $urandom_range(0, 10);
  endfunction

  // Driver: present items from the pending queue, predict on acceptance.
  int gap_left;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        rate_item_t acc;
        acc.action    = in_action;
        acc.ratio     = in_ratio_sample;
        acc.send_us   = in_min_send_time_us;
        acc.congested = in_mac_congested;
        exp_mem[exp_tail] = next_rate_update(acc);
        exp_tail++;
      end
      // Hold the item until it is taken.
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pend_tail > pend_head) begin
          rate_item_t nx;
          nx = pend_mem[pend_head];
          pend_head++;
          in_action           <= nx.action;
          in_ratio_sample     <= nx.ratio;
          in_min_send_time_us <= nx.send_us;
          in_mac_congested    <= nx.congested;
          in_valid            <= 1'b1;
          gap_left            <= draw_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted update against the oldest expectation.
  int stall_left;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        rate_update_t w;
        if (exp_head == exp_tail) begin
          $display("update with nothing expected at %0t", $realtime);
          mismatch_count++;
        end else begin
          w = exp_mem[exp_head];
          exp_head++;
          if (out_mode !== w.mode) report_mismatch("mode", 32'(out_mode), 32'(w.mode));
          if (out_send_rate !== w.rate) report_mismatch("rate", out_send_rate, w.rate);
          if (out_mac_rate_control !== w.mac_rc)
            report_mismatch("mac_rate_control", 32'(out_mac_rate_control), 32'(w.mac_rc));
          if (out_send_now !== w.send_now)
            report_mismatch("send_now", 32'(out_send_now), 32'(w.send_now));
          if (out_timer_command !== w.tmr)
            report_mismatch("timer_command", 32'(out_timer_command), 32'(w.tmr));
        end
        stall_left = draw_gap();
        out_ready <= (stall_left == 0);
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= (stall_left == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: drop the run if work is outstanding and nothing moves.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
        idle_cycles <= 0;
      end else if (in_valid || pend_tail > pend_head || exp_tail > exp_head) begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  // Write one register; the shadow copy follows at the write edge.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_LOW_TH:  begin sh_lo_init = val[15:0]; th_lo = val[15:0]; end
      REG_HIGH_TH: begin sh_hi_init = val[15:0]; th_hi = val[15:0]; end
      REG_SETTLE:  sh_settle  = val[4:0];
      REG_BLOCKED: sh_blocked = val[5:0];
      REG_TOL:     sh_tol     = val[19:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pend_tail > pend_head || in_valid || exp_tail > exp_head)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic add_item(logic a, logic [15:0] r, logic [23:0] t, logic cg);
    rate_item_t it;
    it.action = a; it.ratio = r; it.send_us = t; it.congested = cg;
    pend_mem[pend_tail] = it;
    pend_tail++;
  endtask

  // Random phase: mostly samples in bands around a nominal ratio, mixed
  // with timer items; a few samples are pure noise.
  task automatic random_phase(int n, int cong_pct);
    int          pick;
    logic [15:0] r;
    logic [23:0] t;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0:       t = 24'd0;
        1:       t = 24'hFF_FFFF;
        2:       t = 24'($urandom);
        default: t = 24'($urandom_range(50, 8000));
      endcase
      if (pick < 30) begin
        add_item(1'b1, 16'($urandom), t, ($urandom_range(0, 99) < cong_pct));
      end else begin
        case ($urandom_range(0, 9))
          0:       r = 16'($urandom);
          1, 2, 3: r = 16'($urandom_range(150, 331));
          4, 5, 6: r = 16'($urandom_range(332, 383));
          default: r = 16'($urandom_range(384, 700));
        endcase
        add_item(1'b0, r, t, 1'($urandom));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; in_action = 1'b0; in_ratio_sample = '0;
    in_min_send_time_us = '0; in_mac_congested = 1'b0;
    out_ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    pend_head = 0; pend_tail = 0; exp_head = 0; exp_tail = 0;
    mismatch_count = 0; idle_cycles = 0; gap_left = 0; stall_left = 0;
    quiet_phase = 1'b0;
    sh_lo_init = 16'd0; sh_hi_init = 16'd0;
    sh_settle = 5'd7; sh_blocked = 6'd10; sh_tol = 20'd1000;
    sh_mode = MODE_UNPACED;
    rate_now = 0; rate_top = 0; rate_floor = 0; rate_peak = 0;
    th_lo = 16'd0; th_hi = 16'd0;
    cls_cnt = 0; n_below = 0; n_inside = 0; n_above = 0;
    cg_cnt = 0; cg_total = 0; sat_flag = 0;
    for (int i = 0; i < 10; i++) cls_win[i] = CLS_BELOW;
    for (int i = 0; i < 20; i++) cg_win[i] = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: timer while unpaced, zero and maximum send time,
    // ratio extremes and doubling up to the peak.
    add_item(1'b1, 16'h0000, 24'd0, 1'b1);
    add_item(1'b1, 16'hFFFF, 24'hFF_FFFF, 1'b0);
    add_item(1'b0, 16'd512, 24'd0, 1'b0);
    add_item(1'b0, 16'd0, 24'd0, 1'b0);
    add_item(1'b0, 16'd0, 24'd0, 1'b0);
    add_item(1'b0, 16'hFFFF, 24'd0, 1'b0);
    add_item(1'b0, 16'hFFFF, 24'd0, 1'b0);
    add_item(1'b1, 16'd0, 24'd0, 1'b1);
    add_item(1'b1, 16'd0, 24'd0, 1'b0);
    drain();
    write_reg(REG_BLOCKED, 32'd0);
    write_reg(REG_SETTLE, 32'd0);
    write_reg(REG_TOL, 32'hF_FFFF);
    // Saturation forces a halved search.
    add_item(1'b0, 16'hFFFF, 24'hFF_FFFF, 1'b0);
    add_item(1'b0, 16'd1, 24'd1, 1'b0);
    add_item(1'b1, 16'd0, 24'd0, 1'b1);
    add_item(1'b0, 16'd512, 24'd1, 1'b0);
    add_item(1'b1, 16'd0, 24'd0, 1'b0);
    add_item(1'b0, 16'd360, 24'd1, 1'b0);
    add_item(1'b0, 16'd360, 24'd1, 1'b0);
    add_item(1'b0, 16'd0, 24'd1, 1'b0);
    add_item(1'b0, 16'd0, 24'd1, 1'b0);
    drain();

    // Random phases across register settings, extremes included.
    for (int ph = 0; ph < 12; ph++) begin
      quiet_phase = (ph % 4 == 3);
      case (ph % 6)
        0: begin
          write_reg(REG_SETTLE, 32'd7); write_reg(REG_BLOCKED, 32'd10);
          write_reg(REG_TOL, 32'd1000);
        end
        1: begin
          write_reg(REG_SETTLE, 32'd0); write_reg(REG_BLOCKED, 32'd32);
          write_reg(REG_TOL, 32'd0);
        end
        2: begin
          write_reg(REG_SETTLE, 32'd16); write_reg(REG_BLOCKED, 32'd3);
          write_reg(REG_TOL, 32'hF_FFFF);
        end
        3: begin
          write_reg(REG_SETTLE, $urandom_range(0, 16));
          write_reg(REG_BLOCKED, $urandom_range(0, 32));
          write_reg(REG_TOL, $urandom_range(0, 5000));
        end
        4: begin
          write_reg(REG_SETTLE, 32'd3); write_reg(REG_BLOCKED, 32'd0);
          write_reg(REG_TOL, 32'd100);
        end
        default: begin
          write_reg(REG_SETTLE, 32'd5); write_reg(REG_BLOCKED, 32'd6);
          write_reg(REG_TOL, $urandom);
        end
      endcase
      write_reg(REG_LOW_TH, (ph % 3 == 0) ? 32'hFFFF : $urandom);
      write_reg(REG_HIGH_TH, (ph % 3 == 1) ? 32'h0000 : $urandom);
      random_phase(100, (ph % 2) ? 80 : 20);
      drain();
    end

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/rts_pkg.sv
rtl/rts_datapath.sv
rtl/rts_ctrl.sv
rtl/rts_ratio_send_rate_controller.sv
test/tb_rts_ratio_send_rate_controller.sv
